@@ rtl/core/escaped_separator_splitter_defines.svh @@
// assertion macros shared by the splitter checkers
`ifndef ESCAPED_SEPARATOR_SPLITTER_DEFINES_SVH
`define ESCAPED_SEPARATOR_SPLITTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ESS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ESS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ess_pkg.sv @@
// shared types, constants and helpers of the escaped separator splitter
package ess_pkg;

  // default sizing
  localparam int MAX_SEP_BYTES_DEF = 8;
  localparam int MAX_ESC_BYTES_DEF = 8;
  localparam int OFFSET_BITS_DEF   = 16;

  // fixed field widths
  localparam int BYTE_BITS    = 8;
  localparam int FIELD_BITS   = 16;
  localparam int SPLIT_BITS   = 16;
  localparam int LEN_CFG_BITS = 4;
  localparam int PATTERN_BITS = 64;
  localparam int CFG_IDX_BITS = 3;
  // history cell index width, covers up to 8 + 8 cells
  localparam int HIST_IDX_BITS = 5;
  // byte select inside a 64-bit pattern
  localparam int BYTE_SEL_BITS = 3;

  // result queue depth, power of two, at least four
  localparam int RES_FIFO_DEPTH = 8;

  // configuration register reset values
  localparam logic [PATTERN_BITS-1:0] SEP_BYTES_RST  = 64'd44;
  localparam logic [LEN_CFG_BITS-1:0] SEP_LEN_RST    = 4'd1;
  localparam logic [PATTERN_BITS-1:0] ESC_BYTES_RST  = 64'd0;
  localparam logic [LEN_CFG_BITS-1:0] ESC_LEN_RST    = 4'd0;
  localparam logic [SPLIT_BITS-1:0]   SPLIT_LIMIT_RST = 16'hFFFF;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SEP_BYTES   = 3'd0,
    REG_SEP_LENGTH  = 3'd1,
    REG_ESC_BYTES   = 3'd2,
    REG_ESC_LENGTH  = 3'd3,
    REG_SPLIT_LIMIT = 3'd4,
    REG_EMIT_SEPS   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data_byte;
    logic                 end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] piece_offset;
    logic [FIELD_BITS-1:0] piece_length;
    logic                  is_separator;
    logic                  final_piece;
    logic                  offset_overflow;
  } out_item_t;

  // per-cell compare status handed to the match logic
  typedef struct packed {
    logic sep_ok;
    logic esc_ok;
  } cell_stat_t;

  // low 16 bits of a position of up to 32 bits
  function automatic logic [FIELD_BITS-1:0] to_field(input logic [31:0] v);
    return v[FIELD_BITS-1:0];
  endfunction

endpackage

@@ rtl/core/ess_cell.sv @@
// one history cell: holds a byte, shifts it on, compares against its pattern bytes
module ess_cell #(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  logic                               shift_en,
  input  logic [ess_pkg::BYTE_BITS-1:0]      byte_in,
  input  logic [ess_pkg::LEN_CFG_BITS-1:0]   sep_len,
  input  logic [ess_pkg::LEN_CFG_BITS-1:0]   esc_len,
  input  logic [ess_pkg::PATTERN_BITS-1:0]   sep_bytes,
  input  logic [ess_pkg::PATTERN_BITS-1:0]   esc_bytes,
  output logic [ess_pkg::BYTE_BITS-1:0]      byte_out,
  output ess_pkg::cell_stat_t                stat
);

  localparam logic [ess_pkg::HIST_IDX_BITS-1:0] MY_IDX = ess_pkg::HIST_IDX_BITS'(IDX);

  logic [ess_pkg::BYTE_BITS-1:0]     byte_r;
  logic [ess_pkg::HIST_IDX_BITS-1:0] sl_w;
  logic [ess_pkg::HIST_IDX_BITS-1:0] el_w;
  logic [ess_pkg::HIST_IDX_BITS-1:0] sep_k;
  logic [ess_pkg::HIST_IDX_BITS-1:0] esc_k;
  logic [ess_pkg::BYTE_BITS-1:0]     sep_ref;
  logic [ess_pkg::BYTE_BITS-1:0]     esc_ref;
  logic                              in_sep;
  logic                              in_esc;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  always_comb begin
    sl_w   = ess_pkg::HIST_IDX_BITS'(sep_len);
    el_w   = ess_pkg::HIST_IDX_BITS'(esc_len);
    // cell 0 holds the newest byte, so it meets the last separator byte
    sep_k  = sl_w - 1'b1 - MY_IDX;
    esc_k  = sl_w + el_w - 1'b1 - MY_IDX;
    in_sep = (MY_IDX < sl_w);
    in_esc = (MY_IDX >= sl_w) && (MY_IDX < (sl_w + el_w));
    sep_ref = sep_bytes[ess_pkg::BYTE_BITS*sep_k[ess_pkg::BYTE_SEL_BITS-1:0] +:
                        ess_pkg::BYTE_BITS];
    esc_ref = esc_bytes[ess_pkg::BYTE_BITS*esc_k[ess_pkg::BYTE_SEL_BITS-1:0] +:
                        ess_pkg::BYTE_BITS];
    stat.sep_ok = !in_sep || (byte_r == sep_ref);
    stat.esc_ok = !in_esc || (byte_r == esc_ref);
  end

endmodule

@@ rtl/core/ess_result_fifo.sv @@
// result queue: up to two pushes per cycle, one pop
module ess_result_fifo #(
  parameter int DEPTH = ess_pkg::RES_FIFO_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_cnt,
  input  ess_pkg::out_item_t   push_d0,
  input  ess_pkg::out_item_t   push_d1,
  input  logic                 pop,
  output ess_pkg::out_item_t   head,
  output logic                 not_empty,
  output logic                 room_ok
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 4);

  ess_pkg::out_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] wr_ptr_p1;
  logic          do_pop;

  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign do_pop    = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + PW'(do_pop);
    cnt_nxt    = cnt_r + CW'(push_cnt) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push_d0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_d1;
    end
  end

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  // room for the item in the match stage and one more, two results each
  assign room_ok   = (cnt_r <= ROOM_LIMIT);

endmodule

@@ rtl/core/escaped_separator_splitter.sv @@
// top level of the escaped separator splitter: history cells, match stage, result queue
// an item is registered in the cells, then its results in the result queue, before output
// throughput: one byte per cycle; in_stall rises while the result queue holds more than
//   four results, since a byte makes up to two results and only one leaves per cycle
// reset: synchronous active-low rst_n clears string state and queue, restores the
//   configuration defaults; history bytes are not cleared
module escaped_separator_splitter #(
  parameter int MAX_SEP_BYTES = ess_pkg::MAX_SEP_BYTES_DEF,
  parameter int MAX_ESC_BYTES = ess_pkg::MAX_ESC_BYTES_DEF,
  parameter int OFFSET_BITS   = ess_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input item channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ess_pkg::in_item_t                 in_data,
  // result item channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output ess_pkg::out_item_t                out_data,
  // configuration write port
  input  logic                              cfg_wr_en,
  input  logic [ess_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ess_pkg::PATTERN_BITS-1:0]  cfg_wdata
);

  localparam int HIST_DEPTH = MAX_SEP_BYTES + MAX_ESC_BYTES;
  localparam int W          = OFFSET_BITS;
  localparam logic [W-1:0] OFFSET_MAX = {W{1'b1}};
  localparam logic [ess_pkg::LEN_CFG_BITS-1:0] SEP_CAP =
    ess_pkg::LEN_CFG_BITS'(MAX_SEP_BYTES);
  localparam logic [ess_pkg::LEN_CFG_BITS-1:0] ESC_CAP =
    ess_pkg::LEN_CFG_BITS'(MAX_ESC_BYTES);

  // configuration registers
  logic [ess_pkg::PATTERN_BITS-1:0] sep_bytes_r;
  logic [ess_pkg::LEN_CFG_BITS-1:0] sep_len_r;
  logic [ess_pkg::PATTERN_BITS-1:0] esc_bytes_r;
  logic [ess_pkg::LEN_CFG_BITS-1:0] esc_len_r;
  logic [ess_pkg::SPLIT_BITS-1:0]   split_limit_r;
  logic                             emit_seps_r;

  // clamped lengths seen by the cells and the match logic
  logic [ess_pkg::LEN_CFG_BITS-1:0] sl_eff;
  logic [ess_pkg::LEN_CFG_BITS-1:0] el_eff;

  // handshake
  logic in_accept;
  logic fifo_room;

  // history chain: cell i holds the byte taken i items ago
  logic [ess_pkg::BYTE_BITS-1:0] chain [HIST_DEPTH+1];
  ess_pkg::cell_stat_t           stat  [HIST_DEPTH];
  logic [HIST_DEPTH-1:0]         sep_ok_vec;
  logic [HIST_DEPTH-1:0]         esc_ok_vec;

  // match stage: the item whose byte now sits in cell 0
  logic pipe_v_r, pipe_v_nxt;
  logic pipe_last_r;

  // per-string state
  logic [W-1:0]                   cur_r,    cur_nxt;
  logic [W-1:0]                   pstart_r, pstart_nxt;
  logic [ess_pkg::SPLIT_BITS-1:0] splits_r, splits_nxt;
  logic                           ovf_r,    ovf_nxt;

  // match stage datapath
  logic         ovf_now;
  logic [W-1:0] cur_p1;
  logic [W-1:0] sl_w;
  logic [W-1:0] el_w;
  logic [W-1:0] start_pos;
  logic [W-1:0] end_pos;
  logic [W-1:0] fin_len;
  logic         sep_eq;
  logic         esc_hit;
  logic         matched;
  logic [1:0]   push_cnt;
  ess_pkg::out_item_t piece_a;
  ess_pkg::out_item_t piece_b;
  ess_pkg::out_item_t piece_f;
  ess_pkg::out_item_t push_d0;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_bytes_r   <= ess_pkg::SEP_BYTES_RST;
      sep_len_r     <= ess_pkg::SEP_LEN_RST;
      esc_bytes_r   <= ess_pkg::ESC_BYTES_RST;
      esc_len_r     <= ess_pkg::ESC_LEN_RST;
      split_limit_r <= ess_pkg::SPLIT_LIMIT_RST;
      emit_seps_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (ess_pkg::cfg_reg_t'(cfg_index))
        ess_pkg::REG_SEP_BYTES:   sep_bytes_r   <= cfg_wdata;
        ess_pkg::REG_SEP_LENGTH:  sep_len_r     <= cfg_wdata[ess_pkg::LEN_CFG_BITS-1:0];
        ess_pkg::REG_ESC_BYTES:   esc_bytes_r   <= cfg_wdata;
        ess_pkg::REG_ESC_LENGTH:  esc_len_r     <= cfg_wdata[ess_pkg::LEN_CFG_BITS-1:0];
        ess_pkg::REG_SPLIT_LIMIT: split_limit_r <= cfg_wdata[ess_pkg::SPLIT_BITS-1:0];
        ess_pkg::REG_EMIT_SEPS:   emit_seps_r   <= cfg_wdata[0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // zero length separator acts as one byte; both lengths cap at the cell budget
  always_comb begin
    if (sep_len_r == '0) begin
      sl_eff = ess_pkg::LEN_CFG_BITS'(1);
    end else if (sep_len_r > SEP_CAP) begin
      sl_eff = SEP_CAP;
    end else begin
      sl_eff = sep_len_r;
    end
    el_eff = (esc_len_r > ESC_CAP) ? ESC_CAP : esc_len_r;
  end

  // ------------------------------------------------------------- handshake
  assign in_stall   = !fifo_room;
  assign in_accept  = in_valid && !in_stall;
  assign pipe_v_nxt = in_accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_v_r <= 1'b0;
    end else begin
      pipe_v_r <= pipe_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pipe_last_r <= in_data.end_of_string;
    end
  end

  // ---------------------------------------------------------- history chain
  // bytes step one cell further on every accepted item; stale bytes from an
  // earlier string never reach a compare, the position checks keep them out
  assign chain[0] = in_data.data_byte;

  for (genvar gi = 0; gi < HIST_DEPTH; gi++) begin : g_cell
    ess_cell #(
      .IDX (gi)
    ) u_cell (
      .clk       (clk),
      .shift_en  (in_accept),
      .byte_in   (chain[gi]),
      .sep_len   (sl_eff),
      .esc_len   (el_eff),
      .sep_bytes (sep_bytes_r),
      .esc_bytes (esc_bytes_r),
      .byte_out  (chain[gi+1]),
      .stat      (stat[gi])
    );
    assign sep_ok_vec[gi] = stat[gi].sep_ok;
    assign esc_ok_vec[gi] = stat[gi].esc_ok;
  end

  // ------------------------------------------------------------ match stage
  always_comb begin
    // a byte landing on the last counter value marks the string overflowed
    ovf_now   = ovf_r || (cur_r == OFFSET_MAX);
    cur_p1    = cur_r + 1'b1;
    sl_w      = W'(sl_eff);
    el_w      = W'(el_eff);
    start_pos = cur_p1 - sl_w;
    sep_eq    = &sep_ok_vec;
    // escape only counts when all of it lies inside the string
    esc_hit   = (el_eff != '0) && (start_pos >= el_w) && (&esc_ok_vec);

    matched = pipe_v_r && !ovf_now && (cur_p1 >= sl_w) &&
              (start_pos >= pstart_r) && (splits_r < split_limit_r) &&
              sep_eq && !esc_hit;

    // final piece runs to the byte after this one, or stops at the counter top
    end_pos = ovf_now ? OFFSET_MAX : cur_p1;
    fin_len = (end_pos >= pstart_r) ? (end_pos - pstart_r) : '0;

    // text piece before the separator
    piece_a.piece_offset    = ess_pkg::to_field(32'(pstart_r));
    piece_a.piece_length    = ess_pkg::to_field(32'(start_pos - pstart_r));
    piece_a.is_separator    = 1'b0;
    piece_a.final_piece     = pipe_last_r && !emit_seps_r;
    piece_a.offset_overflow = ovf_now;

    // the separator itself
    piece_b.piece_offset    = ess_pkg::to_field(32'(start_pos));
    piece_b.piece_length    = ess_pkg::to_field(32'(sl_w));
    piece_b.is_separator    = 1'b1;
    piece_b.final_piece     = pipe_last_r;
    piece_b.offset_overflow = ovf_now;

    // trailing piece on the last byte when no match closed the string
    piece_f.piece_offset    = ess_pkg::to_field(32'(pstart_r));
    piece_f.piece_length    = ess_pkg::to_field(32'(fin_len));
    piece_f.is_separator    = 1'b0;
    piece_f.final_piece     = 1'b1;
    piece_f.offset_overflow = ovf_now;

    push_d0 = matched ? piece_a : piece_f;
    if (matched) begin
      push_cnt = emit_seps_r ? 2'd2 : 2'd1;
    end else if (pipe_v_r && pipe_last_r) begin
      push_cnt = 2'd1;
    end else begin
      push_cnt = 2'd0;
    end
  end

  // string state update
  always_comb begin
    cur_nxt    = cur_r;
    pstart_nxt = pstart_r;
    splits_nxt = splits_r;
    ovf_nxt    = ovf_r;
    if (pipe_v_r) begin
      if (pipe_last_r) begin
        cur_nxt    = '0;
        pstart_nxt = '0;
        splits_nxt = '0;
        ovf_nxt    = 1'b0;
      end else begin
        ovf_nxt = ovf_now;
        if (matched) begin
          pstart_nxt = cur_p1;
          splits_nxt = splits_r + 1'b1;
        end
        // position saturates at the counter top
        if (cur_r != OFFSET_MAX) begin
          cur_nxt = cur_p1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= '0;
      pstart_r <= '0;
      splits_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      cur_r    <= cur_nxt;
      pstart_r <= pstart_nxt;
      splits_r <= splits_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // ----------------------------------------------------------- result queue
  ess_result_fifo #(
    .DEPTH (ess_pkg::RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_d0   (push_d0),
    .push_d1   (piece_b),
    .pop       (!out_stall),
    .head      (out_data),
    .not_empty (out_valid),
    .room_ok   (fifo_room)
  );

endmodule

@@ rtl/core/ess_checker.sv @@
// port-level checks of the splitter, bound to the top level
`include "escaped_separator_splitter_defines.svh"

module ess_checker #(
  parameter int MAX_SEP_BYTES = ess_pkg::MAX_SEP_BYTES_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ess_pkg::out_item_t out_data
);

  logic in_take;
  logic out_wait;
  logic sep_piece;
  logic sep_shape_ok;

  assign in_take      = in_valid && !in_stall;
  assign out_wait     = out_valid && out_stall;
  assign sep_piece    = out_valid && out_data.is_separator;
  // a separator piece is never taken on an overflowed string and spans the separator
  assign sep_shape_ok = !out_data.offset_overflow && (out_data.piece_length != '0) &&
                        (out_data.piece_length <= 16'(MAX_SEP_BYTES));

  // a waiting result holds until taken
  `ESS_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_data), "result changed in stall")

  `ESS_ASSERT_NOW(a_sep_piece, sep_piece, sep_shape_ok, "bad separator piece")

  // results appear from an empty queue only after an item is taken and matched into the queue
  `ESS_ASSERT_NOW(a_out_cause, $rose(out_valid), $past(in_take, 2), "result without an item")

endmodule

bind escaped_separator_splitter ess_checker #(
  .MAX_SEP_BYTES (MAX_SEP_BYTES)
) u_ess_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/tb_escaped_separator_splitter.sv @@
// testbench for the escaped separator splitter: directed table and random strings
`timescale 1ns / 100ps

module tb_escaped_separator_splitter;
  import ess_pkg::*;

  localparam int UNTYPED       = -1;    // row result comes from the predictor
  localparam int SETTLE_CYCLES = 4;     // settle margin after the last due piece is back
  localparam int STALL_LIMIT   = 1000;  // cycles with no handshake before giving up
  localparam int SET_ITEMS     = 120;   // random items per configuration setting
  localparam out_item_t NO_PIECE = '0;

  typedef out_item_t piece_pair_t [2];
  typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

  // one directed step: either an item or a register write
  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    sel;
    logic [63:0] wval;
    logic [7:0]  dbyte;
    bit          eos;
    int          n_typed;
    out_item_t   p0;
    out_item_t   p1;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [PATTERN_BITS-1:0] cfg_wdata = '0;

  // typed expectation travels with the item it belongs to
  int typed_n = UNTYPED;
  out_item_t typed_p0 = NO_PIECE;
  out_item_t typed_p1 = NO_PIECE;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  out_item_t pieces_due [$];

  // predictor copy of the configuration, reset values
  logic [63:0] sep_pat = 64'd44;
  logic [3:0]  sep_len = 4'd1;
  logic [63:0] esc_pat = 64'd0;
  logic [3:0]  esc_len = 4'd0;
  logic [15:0] split_cap = 16'hFFFF;
  bit          emit_seps = 1'b0;

  // predictor copy of the per-string state
  logic [7:0]  hist [16] = '{default: 8'h00};
  int unsigned str_pos = 0;
  int unsigned piece_from = 0;
  int unsigned scan_from = 0;
  int unsigned splits_made = 0;
  bit          pos_ovf = 1'b0;

  // directed table: typed results only where obvious, the rest go to the predictor
  stim_row_t dir_tab [28] = '{
    // default comma separator right after reset
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h61, 1'b0, 0, NO_PIECE, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h2C, 1'b0, 1,
      '{16'd0, 16'd1, 1'b0, 1'b0, 1'b0}, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h62, 1'b1, 1,
      '{16'd2, 16'd1, 1'b0, 1'b1, 1'b0}, NO_PIECE},
    // lone separator as last byte, no empty trailing piece
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h2C, 1'b1, 1,
      '{16'd0, 16'd0, 1'b0, 1'b1, 1'b0}, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h2C, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h2C, 1'b1, UNTYPED, NO_PIECE, NO_PIECE},
    // byte extremes
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h00, 1'b0, 0, NO_PIECE, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'hFF, 1'b1, 1,
      '{16'd0, 16'd2, 1'b0, 1'b1, 1'b0}, NO_PIECE},
    // two-byte separator, one-byte escape, separators reported
    '{ROW_WRITE, REG_SEP_BYTES, 64'h3A3A, 8'h00, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_WRITE, REG_SEP_LENGTH, 64'd2, 8'h00, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_WRITE, REG_ESC_BYTES, 64'h5C, 8'h00, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_WRITE, REG_ESC_LENGTH, 64'd1, 8'h00, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_WRITE, REG_EMIT_SEPS, 64'd1, 8'h00, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    // escape at offset 0 hides the first match, the trailing one is taken
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h5C, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h3A, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h3A, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h78, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h3A, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h3A, 1'b1, UNTYPED, NO_PIECE, NO_PIECE},
    // zero separator length acts as one, split limit of zero splits nothing
    '{ROW_WRITE, REG_SEP_LENGTH, 64'd0, 8'h00, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_WRITE, REG_SPLIT_LIMIT, 64'd0, 8'h00, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h3A, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h61, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h3A, 1'b1, UNTYPED, NO_PIECE, NO_PIECE},
    // limit of one: first split taken, the second is not
    '{ROW_WRITE, REG_SPLIT_LIMIT, 64'd1, 8'h00, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h3A, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h61, 1'b0, UNTYPED, NO_PIECE, NO_PIECE},
    '{ROW_ITEM, REG_SEP_BYTES, 64'd0, 8'h3A, 1'b1, UNTYPED, NO_PIECE, NO_PIECE}
  };

  escaped_separator_splitter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic out_item_t make_piece(input int unsigned off, input int unsigned len,
                                           input bit sep, input bit fin, input bit ovf);
    out_item_t p;
    p.piece_offset    = 16'(off);
    p.piece_length    = 16'(len);
    p.is_separator    = sep;
    p.final_piece     = fin;
    p.offset_overflow = ovf;
    return p;
  endfunction

  // advance the string state by one byte, return the pieces it closes
  function automatic int predict_pieces(input in_item_t it, output piece_pair_t got);
    int unsigned sl, el, cur, start, stop, len;
    bit hit, eq, escaped;
    int n;
    got = '{NO_PIECE, NO_PIECE};
    n = 0;
    hit = 1'b0;
    // out-of-range lengths clamp to what the window holds
    sl = (sep_len == 0) ? 1 : ((sep_len > 8) ? 8 : sep_len);
    el = (esc_len > 8) ? 8 : esc_len;
    cur = str_pos;
    for (int k = 15; k > 0; k--) hist[k] = hist[k-1];
    hist[0] = it.data_byte;
    if (cur >= 32'hFFFF) pos_ovf = 1'b1;
    if (!pos_ovf && cur + 1 >= sl) begin
      start = cur + 1 - sl;
      if (start >= scan_from && splits_made < split_cap) begin
        eq = 1'b1;
        for (int k = 0; k < sl; k++)
          if (hist[sl-1-k] != sep_pat[8*k +: 8]) eq = 1'b0;
        // escape must sit wholly inside the string, offset 0 included
        if (eq && el > 0 && start >= el) begin
          escaped = 1'b1;
          for (int k = 0; k < el; k++)
            if (hist[sl+el-1-k] != esc_pat[8*k +: 8]) escaped = 1'b0;
          if (escaped) eq = 1'b0;
        end
        if (eq) begin
          hit = 1'b1;
          splits_made++;
          got[n] = make_piece(piece_from, start - piece_from, 1'b0, 1'b0, pos_ovf);
          n++;
          if (emit_seps) begin
            got[n] = make_piece(start, sl, 1'b1, 1'b0, pos_ovf);
            n++;
          end
          piece_from = cur + 1;
          scan_from = cur + 1;
        end
      end
    end
    if (it.end_of_string) begin
      if (hit) begin
        got[n-1].final_piece = 1'b1;
      end else begin
        // after overflow the piece ends at the saturated position
        stop = pos_ovf ? 32'hFFFF : cur + 1;
        len = (stop >= piece_from) ? stop - piece_from : 0;
        got[n] = make_piece(piece_from, len, 1'b0, 1'b1, pos_ovf);
        n++;
      end
      hist = '{default: 8'h00};
      str_pos = 0;
      piece_from = 0;
      scan_from = 0;
      splits_made = 0;
      pos_ovf = 1'b0;
    end else if (cur < 32'hFFFF) begin
      str_pos = cur + 1;
    end
    return n;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  // input side predicts, output side checks; one block keeps the order fixed
  always @(posedge clk) begin : check_pieces
    piece_pair_t made;
    out_item_t due;
    int n;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n = predict_pieces(in_data, made);
        if (typed_n != UNTYPED) begin
          n = typed_n;
          made = '{typed_p0, typed_p1};
        end
        for (int i = 0; i < n; i++) pieces_due.push_back(made[i]);
      end
      if (out_valid && !out_stall) begin
        if (pieces_due.size() == 0) begin
          report_mismatch($sformatf("piece off=%0d len=%0d with nothing expected",
                                    out_data.piece_offset, out_data.piece_length));
        end else begin
          due = pieces_due.pop_front();
          if (out_data.piece_offset !== due.piece_offset)
            report_mismatch($sformatf("piece_offset got %0d expected %0d",
                                      out_data.piece_offset, due.piece_offset));
          if (out_data.piece_length !== due.piece_length)
            report_mismatch($sformatf("piece_length got %0d expected %0d",
                                      out_data.piece_length, due.piece_length));
          if (out_data.is_separator !== due.is_separator)
            report_mismatch($sformatf("is_separator got %b expected %b",
                                      out_data.is_separator, due.is_separator));
          if (out_data.final_piece !== due.final_piece)
            report_mismatch($sformatf("final_piece got %b expected %b",
                                      out_data.final_piece, due.final_piece));
          if (out_data.offset_overflow !== due.offset_overflow)
            report_mismatch($sformatf("offset_overflow got %b expected %b",
                                      out_data.offset_overflow, due.offset_overflow));
        end
      end
    end
  end

  // watchdog: too long without any handshake means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // offer one item, with random sender gaps, and hold it until taken
  task automatic push_item(input logic [7:0] b, input bit eos, input int tn,
                           input out_item_t t0, input out_item_t t1);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, end_of_string: eos};
    typed_n  <= tn;
    typed_p0 <= t0;
    typed_p1 <= t1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending, wait for every due piece, then let the pipeline settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pieces_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [63:0] val);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (sel)
      REG_SEP_BYTES:   sep_pat = val;
      REG_SEP_LENGTH:  sep_len = val[3:0];
      REG_ESC_BYTES:   esc_pat = val;
      REG_ESC_LENGTH:  esc_len = val[3:0];
      REG_SPLIT_LIMIT: split_cap = val[15:0];
      REG_EMIT_SEPS:   emit_seps = val[0];
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // new random setting; upper write data bits are junk the block must ignore
  task automatic pick_setting(input int kind);
    int sl, el, lim;
    bit em;
    case (kind)
      0: begin
        sl = $urandom_range(0, 1);
        el = $urandom_range(0, 1);
        lim = 65535;
        em = 1'($urandom_range(1));
      end
      1: begin
        // widest windows, lengths above the maximum included
        sl = $urandom_range(8, 15);
        el = $urandom_range(8, 15);
        lim = $urandom_range(0, 3);
        em = 1'b1;
      end
      2: begin
        sl = $urandom_range(1, 8);
        el = $urandom_range(0, 8);
        lim = $urandom_range(65535);
        em = 1'($urandom_range(1));
      end
      default: begin
        sl = $urandom_range(2, 4);
        el = $urandom_range(1, 3);
        lim = $urandom_range(1) ? 0 : 2;
        em = 1'b0;
      end
    endcase
    write_reg(REG_SEP_BYTES, rand_word());
    write_reg(REG_ESC_BYTES, rand_word());
    write_reg(REG_SEP_LENGTH, 64'({rand_word() >> 4, 4'(sl)}));
    write_reg(REG_ESC_LENGTH, 64'({rand_word() >> 4, 4'(el)}));
    write_reg(REG_SPLIT_LIMIT, 64'({rand_word() >> 16, 16'(lim)}));
    write_reg(REG_EMIT_SEPS, 64'({rand_word() >> 1, em}));
  endtask

  // string built from separator runs, escaped separators, pattern bytes and noise
  task automatic send_string();
    logic [7:0] str_q [$];
    int want_len, sl, el, pick;
    sl = (sep_len == 0) ? 1 : ((sep_len > 8) ? 8 : sep_len);
    el = (esc_len > 8) ? 8 : esc_len;
    want_len = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
    while (str_q.size() < want_len) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        for (int k = 0; k < sl; k++) str_q.push_back(sep_pat[8*k +: 8]);
      end else if (pick < 40) begin
        for (int k = 0; k < el; k++) str_q.push_back(esc_pat[8*k +: 8]);
        for (int k = 0; k < sl; k++) str_q.push_back(sep_pat[8*k +: 8]);
      end else if (pick < 80) begin
        // loose pattern bytes make partial and broken matches
        if (el > 0 && $urandom_range(1))
          str_q.push_back(esc_pat[8*$urandom_range(el-1) +: 8]);
        else
          str_q.push_back(sep_pat[8*$urandom_range(sl-1) +: 8]);
      end else begin
        str_q.push_back(8'($urandom_range(255)));
      end
    end
    foreach (str_q[i]) begin
      push_item(str_q[i], i == str_q.size() - 1, UNTYPED, NO_PIECE, NO_PIECE);
      items_sent++;
    end
  endtask

  initial begin
    int goal;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table under the first idling mix
    send_idle_pct = 32;
    recv_idle_pct = 66;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_WRITE) begin
        write_reg(dir_tab[i].sel, dir_tab[i].wval);
      end else begin
        push_item(dir_tab[i].dbyte, dir_tab[i].eos, dir_tab[i].n_typed,
                  dir_tab[i].p0, dir_tab[i].p1);
        items_sent++;
      end
    end

    // random strings: sender light / receiver heavy, then swapped, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : ((phase == 1) ? 66 : 0);
      recv_idle_pct = (phase == 0) ? 66 : ((phase == 1) ? 32 : 0);
      for (int s = 0; s < 4; s++) begin
        pick_setting(s);
        goal = items_sent + SET_ITEMS;
        while (items_sent < goal) begin
          send_string();
          // now and then hold off until every piece is back
          if ($urandom_range(49) == 0) drain_results();
        end
      end
    end

    drain_results();
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/ess_pkg.sv
rtl/core/ess_cell.sv
rtl/core/ess_result_fifo.sv
rtl/core/escaped_separator_splitter.sv
rtl/core/ess_checker.sv
tb/tb_escaped_separator_splitter.sv
